### rtl/spr_pkg.sv
// Shared constants, types and helpers of the symmetric padding matrix reader.
package spr_pkg;

	localparam int COORD_W = 16;
	localparam int SIZE_W = 7;
	localparam int WORD_W = 32;
	localparam int CFG_IDX_W = 2;

	localparam int DEF_MAX_ROWS = 64;
	localparam int DEF_MAX_COLS = 64;
	localparam int DEF_DATA_WIDTH = 32;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;

	// request codes
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_READ = 1'b1;

	typedef struct packed {
		logic done;
		logic [SIZE_W-1:0] idx;
	} refl_rsp_t;

	// zero counts as one, anything above the maximum saturates
	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v, input int maxv);
		logic [SIZE_W-1:0] res;
		if (v == '0) begin
			res = 7'd1;
		end else if (int'(v) > maxv) begin
			res = SIZE_W'(maxv);
		end else begin
			res = v;
		end
		return res;
	endfunction

endpackage

### rtl/spr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module spr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/spr_reflect.sv
// Bit-serial restoring divider that folds one signed coordinate onto 0..n-1.
module spr_reflect (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [spr_pkg::COORD_W-1:0]  coord,
	input  logic [spr_pkg::SIZE_W-1:0]          size,
	output spr_pkg::refl_rsp_t                  rsp
);

	import spr_pkg::*;

	localparam int MW = COORD_W - 1;
	localparam int CNT_W = $clog2(MW + 1);

	logic [MW-1:0]     m_q;
	logic [SIZE_W-1:0] rem_q;
	logic [SIZE_W-1:0] n_q;
	logic              qlsb_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [SIZE_W:0]   trial;
	logic              fits;
	logic [SIZE_W-1:0] rem_next;

	always_comb begin
		trial = {rem_q, m_q[MW-1]};
		fits = trial >= {1'b0, n_q};
		rem_next = fits ? SIZE_W'(trial - {1'b0, n_q}) : trial[SIZE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(MW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// a negative coordinate c folds to -c-1, which is the inverted magnitude bits
	always_ff @(posedge clk) begin
		if (start) begin
			m_q <= coord[COORD_W-1] ? ~coord[MW-1:0] : coord[MW-1:0];
			rem_q <= '0;
			n_q <= size;
			qlsb_q <= 1'b0;
		end else if (busy_q) begin
			m_q <= {m_q[MW-2:0], 1'b0};
			rem_q <= rem_next;
			qlsb_q <= fits;
		end
	end

	// mirror the offset on odd tiles
	assign rsp.done = done_q;
	assign rsp.idx = qlsb_q ? SIZE_W'(n_q - 1'b1 - rem_q) : rem_q;

endmodule

### rtl/symmetric_pad_matrix_read.sv
// Matrix store with symmetric reflection padding on reads at signed coordinates.
// Write: no result; stored at the accepting edge only if in range; next item next cycle.
// Read: two parallel bit-serial dividers fold the coordinates, the RAM is read,
// then the result register loads once the result slot is free; the input stays closed
// from the transfer until that load, so a stalled result holds the input off.
// Reset clears control and sets both size registers to 64; RAM contents stay undefined.
module symmetric_pad_matrix_read #(
	parameter int MAX_ROWS = spr_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = spr_pkg::DEF_MAX_COLS,
	parameter int DATA_WIDTH = spr_pkg::DEF_DATA_WIDTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 req_type,
	input  logic signed [spr_pkg::COORD_W-1:0]   row_coord,
	input  logic signed [spr_pkg::COORD_W-1:0]   col_coord,
	input  logic [spr_pkg::WORD_W-1:0]           write_word,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [spr_pkg::WORD_W-1:0]           read_word,
	output logic                                 was_padded,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [spr_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [spr_pkg::SIZE_W-1:0]           cfg_data
);

	import spr_pkg::*;

	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;

	logic [1:0]        state_q;
	logic [SIZE_W-1:0] rows_q;
	logic [SIZE_W-1:0] cols_q;
	logic              padded_q;
	logic              out_valid_q;
	logic [WORD_W-1:0] read_word_q;

	logic [SIZE_W-1:0]     nr;
	logic [SIZE_W-1:0]     nc;
	logic                  in_range;
	logic                  accept;
	logic                  start_rd;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic [DATA_WIDTH-1:0] rd_data;
	logic                  load_out;
	refl_rsp_t             row_rsp;
	refl_rsp_t             col_rsp;

	assign nr = clamp_size(rows_q, MAX_ROWS);
	assign nc = clamp_size(cols_q, MAX_COLS);

	assign in_range = !row_coord[COORD_W-1] && !col_coord[COORD_W-1]
		&& (row_coord[COORD_W-2:0] < (COORD_W-1)'(nr))
		&& (col_coord[COORD_W-2:0] < (COORD_W-1)'(nc));

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	assign start_rd = accept && (req_type == REQ_READ);
	assign wr_en = accept && (req_type == REQ_WRITE) && in_range;
	assign wr_addr = AW'(RW'(row_coord[COORD_W-2:0])) * AW'(MAX_COLS)
		+ AW'(CW'(col_coord[COORD_W-2:0]));

	// in-range reads fold to themselves, so every read goes through the dividers
	spr_reflect u_row (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_rd),
		.coord  (row_coord),
		.size   (nr),
		.rsp    (row_rsp)
	);

	spr_reflect u_col (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_rd),
		.coord  (col_coord),
		.size   (nc),
		.rsp    (col_rsp)
	);

	assign rd_en = (state_q == ST_DIV) && row_rsp.done && col_rsp.done;
	assign rd_addr = AW'(RW'(row_rsp.idx)) * AW'(MAX_COLS) + AW'(CW'(col_rsp.idx));

	spr_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (DATA_WIDTH'(write_word)),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// read data holds until the next read, so wait here for a free result slot
	assign load_out = (state_q == ST_WAIT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rows_q <= SIZE_RESET;
			cols_q <= SIZE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ROWS: rows_q <= cfg_data;
					CFG_COLS: cols_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (start_rd) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (rd_en) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_rd) begin
			padded_q <= !in_range;
		end
		if (load_out) begin
			read_word_q <= WORD_W'(rd_data);
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			was_padded <= padded_q;
		end
	end

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign read_word = read_word_q;

endmodule

### rtl/spr_checker.sv
// Port-level checks for the symmetric padding matrix reader, bound to the top level.
module spr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          req_type,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [spr_pkg::WORD_W-1:0]    read_word,
	input logic                          was_padded,
	input logic                          cfg_ready
);

	import spr_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_word) && $stable(was_padded))
		else $error("result changed while stalled");

	// a read transfer closes the input until its result is loaded
	a_read_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (req_type == REQ_READ) |=> !in_ready)
		else $error("input open during a read");

	// a new result appears only while a read is in progress
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without a read in progress");

	// the configuration port never stalls
	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration port stalled");

endmodule

bind symmetric_pad_matrix_read spr_checker u_spr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.req_type   (req_type),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.read_word  (read_word),
	.was_padded (was_padded),
	.cfg_ready  (cfg_ready)
);

### sim/tb_top.sv
// Self-checking testbench for the symmetric padding matrix reader.
module tb_top;
	import spr_pkg::*;

	localparam int MAX_R = DEF_MAX_ROWS;
	localparam int MAX_C = DEF_MAX_COLS;
	localparam int DRAIN_CYCLES = 24;
	localparam int LONG_HOLD = 300;
	localparam int PHASE_ITEMS = 118;
	localparam int N_PHASES = 10;
	localparam int MAX_REPORTS = 200;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE3 = 2'd3;

	typedef struct {
		logic                      kind;
		logic signed [COORD_W-1:0] row;
		logic signed [COORD_W-1:0] col;
		logic [WORD_W-1:0]         word;
	} mat_req_t;

	typedef struct {
		logic [WORD_W-1:0] word;
		logic              padded;
	} padded_read_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic req_type = REQ_WRITE;
	logic signed [COORD_W-1:0] row_coord = '0;
	logic signed [COORD_W-1:0] col_coord = '0;
	logic [WORD_W-1:0] write_word = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [WORD_W-1:0] read_word;
	logic was_padded;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_ROWS;
	logic [SIZE_W-1:0] cfg_data = '0;

	symmetric_pad_matrix_read u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.row_coord(row_coord),
		.col_coord(col_coord),
		.write_word(write_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_word(read_word),
		.was_padded(was_padded),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// shadow of the matrix and its size registers
	logic [WORD_W-1:0] shadow_mem [MAX_R*MAX_C];
	logic [SIZE_W-1:0] size_rows = SIZE_RESET;
	logic [SIZE_W-1:0] size_cols = SIZE_RESET;
	// cells that the queued stimulus will have written; reads only target these
	bit planned_written [MAX_R*MAX_C];

	mat_req_t pending_reqs[$];
	padded_read_t expected_reads[$];

	int reqs_issued = 0;
	int reqs_accepted = 0;
	int reads_checked = 0;
	int padded_seen = 0;
	int writes_stored = 0;
	int writes_dropped = 0;
	int settings_used = 1;
	int errors = 0;

	int gap_left = 0;
	int calm_items = 0;
	int src_pick;
	mat_req_t next_req;

	int hold_left = 0;
	int open_left = 0;
	bit long_hold_done = 1'b0;
	int sink_pick;

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("symmetric_pad_matrix_read verification failed");
		$finish;
	end

	function automatic int eff_size(input logic [SIZE_W-1:0] v, input int maxv);
		if (v == '0)
			return 1;
		return (int'(v) > maxv) ? maxv : int'(v);
	endfunction

	// half-sample symmetric fold of one axis onto 0..n-1
	function automatic int fold_coord(input logic signed [COORD_W-1:0] c, input int n);
		int m, q, r;
		m = (c < 0) ? -int'(c) - 1 : int'(c);
		q = m / n;
		r = m % n;
		return q[0] ? n - 1 - r : r;
	endfunction

	function automatic int map_cell(input logic signed [COORD_W-1:0] r,
			input logic signed [COORD_W-1:0] c, output logic padded);
		int nr, nc;
		nr = eff_size(size_rows, MAX_R);
		nc = eff_size(size_cols, MAX_C);
		padded = !(r >= 0 && c >= 0 && int'(r) < nr && int'(c) < nc);
		if (!padded)
			return int'(r) * MAX_C + int'(c);
		return fold_coord(r, nr) * MAX_C + fold_coord(c, nc);
	endfunction

	// update the shadow on a transfer and queue the read data it must return
	function automatic void apply_request(input mat_req_t q);
		logic padded;
		int slot;
		padded_read_t e;
		slot = map_cell(q.row, q.col, padded);
		if (q.kind == REQ_WRITE) begin
			if (!padded) begin
				shadow_mem[slot] = q.word;
				writes_stored++;
			end else begin
				writes_dropped++;
			end
		end else begin
			e.word = shadow_mem[slot];
			e.padded = padded;
			expected_reads.push_back(e);
		end
	endfunction

	function automatic int add_write(input int r, input int c, input logic [WORD_W-1:0] w);
		mat_req_t q;
		logic padded;
		int slot;
		q.kind = REQ_WRITE;
		q.row = r[COORD_W-1:0];
		q.col = c[COORD_W-1:0];
		q.word = w;
		slot = map_cell(q.row, q.col, padded);
		if (!padded)
			planned_written[slot] = 1'b1;
		pending_reqs.push_back(q);
		reqs_issued++;
		return padded ? 0 : 1;
	endfunction

	// write the target cell first when nothing has been stored there yet
	function automatic int add_read(input int r, input int c);
		mat_req_t q;
		logic padded;
		int slot, cnt;
		cnt = 1;
		q.kind = REQ_READ;
		q.row = r[COORD_W-1:0];
		q.col = c[COORD_W-1:0];
		q.word = $urandom;
		slot = map_cell(q.row, q.col, padded);
		if (!planned_written[slot])
			cnt += add_write(slot / MAX_C, slot % MAX_C, $urandom);
		pending_reqs.push_back(q);
		reqs_issued++;
		return cnt;
	endfunction

	function automatic int pick_coord(input int n);
		int sel, v;
		sel = $urandom_range(0, 9);
		if (sel < 4) begin
			v = $urandom_range(0, n - 1);
		end else if (sel < 6) begin
			v = int'($urandom_range(0, 4 * n)) - 2 * n;
		end else if (sel == 6) begin
			case ($urandom_range(0, 5))
				0: v = -1;
				1: v = n;
				2: v = -n;
				3: v = n - 1;
				4: v = -n - 1;
				default: v = 2 * n;
			endcase
		end else if (sel == 7) begin
			case ($urandom_range(0, 3))
				0: v = -32768;
				1: v = 32767;
				2: v = 0;
				default: v = -1;
			endcase
		end else begin
			v = int'($urandom_range(0, 65535)) - 32768;
		end
		return v;
	endfunction

	function automatic void fill_random(input int target);
		int cnt, sel, nr, nc;
		cnt = 0;
		nr = eff_size(size_rows, MAX_R);
		nc = eff_size(size_cols, MAX_C);
		while (cnt < target) begin
			sel = $urandom_range(0, 99);
			if (sel < 50)
				cnt += add_read(pick_coord(nr), pick_coord(nc));
			else if (sel < 92)
				cnt += add_write($urandom_range(0, nr - 1), $urandom_range(0, nc - 1), $urandom);
			else
				cnt += add_write(pick_coord(nr), pick_coord(nc), $urandom);
		end
	endfunction

	// corners, dropped writes and folds at the coordinate extremes, at reset size
	function automatic void fill_directed();
		int n;
		n = add_write(0, 0, 32'h0000_0000);
		n = add_write(0, 63, 32'hFFFF_FFFF);
		n = add_write(63, 0, 32'hAAAA_AAAA);
		n = add_write(63, 63, 32'h5555_5555);
		n = add_write(-1, -1, 32'hDEAD_BEEF);
		n = add_write(64, 0, 32'hFFFF_0000);
		n = add_write(0, 64, 32'h0000_FFFF);
		n = add_write(-32768, 32767, 32'h0F0F_0F0F);
		n = add_read(0, 0);
		n = add_read(-1, -1);
		n = add_read(63, 63);
		n = add_read(64, 64);
		n = add_read(-32768, -32768);
		n = add_read(32767, 32767);
		n = add_read(-65, 0);
		n = add_read(127, 0);
		n = add_read(128, -129);
		n = add_read(0, -1);
		n = add_read(-64, 63);
		n = add_read(63, 64);
		n = add_write(0, 0, 32'h1234_5678);
		n = add_read(-1, 0);
	endfunction

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_ROWS)
			size_rows = val;
		else if (idx == CFG_COLS)
			size_cols = val;
	endtask

	task automatic wait_drained();
		while (reqs_accepted != reqs_issued || expected_reads.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			req_type <= REQ_WRITE;
			row_coord <= '0;
			col_coord <= '0;
			write_word <= '0;
			gap_left <= 0;
			calm_items <= 0;
		end else begin
			if (in_valid && in_ready) begin
				apply_request('{req_type, row_coord, col_coord, write_word});
				reqs_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					next_req = pending_reqs.pop_front();
					req_type <= next_req.kind;
					row_coord <= next_req.row;
					col_coord <= next_req.col;
					write_word <= next_req.word;
					in_valid <= 1'b1;
					if (calm_items > 0) begin
						calm_items <= calm_items - 1;
						gap_left <= 0;
					end else begin
						src_pick = $urandom_range(0, 99);
						if (src_pick < 2)
							calm_items <= $urandom_range(30, 80);
						if (src_pick < 55)
							gap_left <= 0;
						else if (src_pick < 93)
							gap_left <= $urandom_range(1, 3);
						else
							gap_left <= $urandom_range(10, 40);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result sink: random back-pressure, one long hold while reads are queued up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			open_left <= 0;
			long_hold_done <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (open_left > 0) begin
			open_left <= open_left - 1;
			out_ready <= 1'b1;
		end else if (!long_hold_done && expected_reads.size() > 0) begin
			out_ready <= 1'b0;
			hold_left <= LONG_HOLD;
			long_hold_done <= 1'b1;
		end else begin
			sink_pick = $urandom_range(0, 99);
			if (sink_pick < 3) begin
				out_ready <= 1'b1;
				open_left <= $urandom_range(50, 150);
			end else if (sink_pick < 60) begin
				out_ready <= 1'b1;
			end else if (sink_pick < 95) begin
				out_ready <= 1'b0;
				hold_left <= $urandom_range(0, 3);
			end else begin
				out_ready <= 1'b0;
				hold_left <= $urandom_range(15, 50);
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		padded_read_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_reads.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected result word=%h padded=%b",
						$time, read_word, was_padded);
			end else begin
				e = expected_reads.pop_front();
				reads_checked++;
				if (was_padded)
					padded_seen++;
				if (read_word !== e.word) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: read_word expected %h actual %h",
							$time, e.word, read_word);
				end
				if (was_padded !== e.padded) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: was_padded expected %b actual %b",
							$time, e.padded, was_padded);
				end
			end
		end
	end

	initial begin
		logic [SIZE_W-1:0] phase_rows [N_PHASES];
		logic [SIZE_W-1:0] phase_cols [N_PHASES];
		int ph;
		// zero, saturating and single-line shapes, then random sizes
		phase_rows = '{7'd0, 7'd127, 7'd1, 7'd65, 7'd64, 7'd7, 7'd0, 7'd0, 7'd0, 7'd0};
		phase_cols = '{7'd0, 7'd1, 7'd127, 7'd64, 7'd65, 7'd3, 7'd0, 7'd0, 7'd0, 7'd0};
		for (ph = 6; ph < N_PHASES; ph++) begin
			phase_rows[ph] = SIZE_W'($urandom_range(1, 64));
			phase_cols[ph] = (ph == N_PHASES - 1) ? SIZE_W'($urandom_range(0, 127))
				: SIZE_W'($urandom_range(1, 64));
		end
		for (ph = 0; ph < MAX_R * MAX_C; ph++) begin
			shadow_mem[ph] = '0;
			planned_written[ph] = 1'b0;
		end
		fill_directed();
		fill_random(PHASE_ITEMS);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		wait_drained();
		for (ph = 0; ph < N_PHASES; ph++) begin
			cfg_write(CFG_ROWS, phase_rows[ph]);
			cfg_write(CFG_COLS, phase_cols[ph]);
			if (ph == 1) begin
				// unused indexes must leave the sizes alone
				cfg_write(CFG_SPARE2, 7'h7F);
				cfg_write(CFG_SPARE3, SIZE_W'($urandom_range(0, 127)));
			end
			settings_used++;
			fill_random(PHASE_ITEMS);
			wait_drained();
		end
		$display("Covered %0d matrix shapes: %0d reads compared (%0d from the border)",
			settings_used, reads_checked, padded_seen);
		$display("%0d stored writes and %0d out-of-range writes dropped, stalls on both sides",
			writes_stored, writes_dropped);
		if (errors == 0)
			$display("symmetric_pad_matrix_read verification clean");
		else
			$display("symmetric_pad_matrix_read verification failed");
		$finish;
	end

endmodule
